>>> rtl/dispenser_supervisory_fsm_assert.svh
// Assertion macros for the dispenser supervisory FSM.
`ifndef DISPENSER_SUPERVISORY_FSM_ASSERT_SVH
`define DISPENSER_SUPERVISORY_FSM_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define DSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsf: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define DSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsf: next-cycle check failed");
`else
`define DSF_ASSERT_IMP(lbl, ante, cons)
`define DSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/dsf_pkg.sv
// Types and codes shared by the dispenser supervisory FSM modules.
package dsf_pkg;

    typedef enum logic [4:0] {
        ST_BOOT      = 5'd0,
        ST_SELF_TEST = 5'd1,
        ST_WARMUP    = 5'd2,
        ST_ZERO      = 5'd3,
        ST_READY     = 5'd4,
        ST_STAGE1    = 5'd5,
        ST_STAGE2    = 5'd6,
        ST_STAGE3    = 5'd7,
        ST_STAGE4    = 5'd8,
        ST_SETTLE    = 5'd9,
        ST_VALIDATE  = 5'd10,
        ST_REPORT    = 5'd11,
        ST_CLEANUP   = 5'd12,
        ST_AUTOCHK   = 5'd13,
        ST_MANCAL    = 5'd14,
        ST_SERVICE   = 5'd15,
        ST_FAULT     = 5'd16,
        ST_ESTOP     = 5'd17
    } state_t;

    typedef enum logic [2:0] {
        RS_NORMAL   = 3'd0,
        RS_FAILED   = 3'd1,
        RS_OPERATOR = 3'd2,
        RS_DISPENSE = 3'd3,
        RS_COMPLETE = 3'd4,
        RS_SUPRESET = 3'd5,
        RS_FAULT    = 3'd6,
        RS_ESTOP    = 3'd7
    } reason_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_VERIFY  = 2'd2,
        STAT_FAULT   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        REQ_BOOT_DONE     = 5'd0,
        REQ_SELFTEST_DONE = 5'd1,
        REQ_WARMUP_DONE   = 5'd2,
        REQ_ZERO_DONE     = 5'd3,
        REQ_DISPENSE      = 5'd4,
        REQ_PLANNER_SYNC  = 5'd5,
        REQ_REPORT_DONE   = 5'd6,
        REQ_CLEANUP_DONE  = 5'd7,
        REQ_AUTOCHK       = 5'd8,
        REQ_AUTOCHK_DONE  = 5'd9,
        REQ_CAL           = 5'd10,
        REQ_CAL_DONE      = 5'd11,
        REQ_SERVICE       = 5'd12,
        REQ_SERVICE_EXIT  = 5'd13,
        REQ_FAULT         = 5'd14,
        REQ_ESTOP         = 5'd15,
        REQ_RESET         = 5'd16
    } req_t;

    typedef enum logic [3:0] {
        PL_IDLE      = 4'd0,
        PL_VERIFY    = 4'd1,
        PL_STAGE1    = 4'd2,
        PL_STAGE2    = 4'd3,
        PL_STAGE3    = 4'd4,
        PL_STAGE4    = 4'd5,
        PL_SETTLE    = 4'd6,
        PL_VALIDATE  = 4'd7,
        PL_COMPLETE  = 4'd8,
        PL_UNDERFILL = 4'd9,
        PL_OVERFILL  = 4'd10,
        PL_FAULT     = 4'd11,
        PL_ESTOP     = 4'd12
    } plan_t;

    localparam logic [2:0] STAGE_NONE = 3'd7;

    // One input event as it sits in the input register
    typedef struct packed {
        logic [4:0] req_type;
        logic       pass_flag;
        logic       faults_clear;
        logic [3:0] planner_state;
    } ev_t;

    // One result as it sits in the output register
    typedef struct packed {
        status_t     status;
        state_t      sys_state;
        state_t      prev_state;
        reason_t     last_reason;
        logic [63:0] transition_count;
        logic        session_active;
        logic        did_transition;
    } res_t;

endpackage

>>> rtl/dsf_in_reg.sv
// Input register stage: holds one accepted event until the core takes it.
module dsf_in_reg
    import dsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  ev_t  ev_in,
    input  logic take,
    output logic ev_vld,
    output ev_t  ev
);

    logic vld_reg;
    logic vld_next;
    ev_t  ev_reg;

    // Accept while empty or while the held event leaves this cycle
    assign in_ready = !vld_reg || take;
    assign ev_vld   = vld_reg;
    assign ev       = ev_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ev_reg <= ev_in;
        end
    end

endmodule

>>> rtl/dsf_core.sv
// Supervisory state registers and the per-event transition logic.
module dsf_core
    import dsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  ev_t  ev,
    output res_t res
);

    state_t      cur_state_reg, cur_state_next;
    logic        session_reg, session_next;
    logic [2:0]  stage_reg, stage_next;
    logic [63:0] count_reg, count_next;
    state_t      rec_prev_reg, rec_prev_next;
    reason_t     rec_reason_reg, rec_reason_next;

    logic        go;
    state_t      go_state;
    reason_t     go_reason;
    status_t     st;
    state_t      tgt;
    logic [2:0]  pstage;
    logic        is_stage;
    logic        allowed;

    // Decode the event against the current state
    always_comb
    begin
        go           = 1'b0;
        go_state     = cur_state_reg;
        go_reason    = RS_NORMAL;
        st           = STAT_INVALID;
        session_next = session_reg;
        stage_next   = stage_reg;
        tgt          = ST_ZERO;
        pstage       = STAGE_NONE;
        is_stage     = 1'b0;
        allowed      = 1'b0;

        unique case (ev.req_type)
            REQ_BOOT_DONE:
            begin
                if (cur_state_reg == ST_BOOT)
                begin
                    go = 1'b1; go_state = ST_SELF_TEST; go_reason = RS_NORMAL; st = STAT_OK;
                end
            end
            REQ_SELFTEST_DONE:
            begin
                if (cur_state_reg == ST_SELF_TEST)
                begin
                    go = 1'b1;
                    if (ev.pass_flag)
                    begin
                        go_state = ST_WARMUP; go_reason = RS_NORMAL; st = STAT_OK;
                    end
                    else
                    begin
                        go_state = ST_FAULT; go_reason = RS_FAILED; st = STAT_VERIFY;
                    end
                end
            end
            REQ_WARMUP_DONE:
            begin
                if (cur_state_reg == ST_WARMUP)
                begin
                    go = 1'b1; go_state = ST_ZERO; go_reason = RS_NORMAL; st = STAT_OK;
                end
            end
            REQ_ZERO_DONE:
            begin
                if (!session_reg && cur_state_reg == ST_ZERO)
                begin
                    go = 1'b1;
                    if (ev.pass_flag)
                    begin
                        go_state = ST_READY; go_reason = RS_NORMAL; st = STAT_OK;
                    end
                    else
                    begin
                        go_state = ST_FAULT; go_reason = RS_FAILED; st = STAT_VERIFY;
                    end
                end
            end
            REQ_DISPENSE:
            begin
                if (cur_state_reg == ST_READY)
                begin
                    go = 1'b1; go_state = ST_ZERO; go_reason = RS_OPERATOR; st = STAT_OK;
                    session_next = 1'b1;
                    stage_next   = STAGE_NONE;
                end
            end
            REQ_PLANNER_SYNC:
            begin
                if (ev.planner_state == PL_ESTOP)
                begin
                    // Planner e-stop acts as the e-stop event but reports STAT_FAULT
                    session_next = 1'b0;
                    stage_next   = STAGE_NONE;
                    st           = STAT_FAULT;
                    if (cur_state_reg != ST_ESTOP)
                    begin
                        go = 1'b1; go_state = ST_ESTOP; go_reason = RS_ESTOP;
                    end
                end
                else if (cur_state_reg == ST_ESTOP || cur_state_reg == ST_FAULT)
                begin
                    st = STAT_FAULT;
                end
                else if (!session_reg || cur_state_reg < ST_ZERO ||
                         cur_state_reg == ST_READY || cur_state_reg > ST_REPORT)
                begin
                    st = STAT_INVALID;
                end
                else if (ev.planner_state == PL_UNDERFILL ||
                         ev.planner_state == PL_OVERFILL ||
                         ev.planner_state == PL_FAULT)
                begin
                    session_next = 1'b0;
                    go = 1'b1; go_state = ST_FAULT; go_reason = RS_FAILED;
                    st = STAT_FAULT;
                end
                else if (ev.planner_state > PL_ESTOP)
                begin
                    st = STAT_INVALID;
                end
                else
                begin
                    // Map the report to a target state
                    if (ev.planner_state <= PL_VERIFY)
                    begin
                        tgt = ST_ZERO;
                    end
                    else if (ev.planner_state <= PL_STAGE4)
                    begin
                        is_stage = 1'b1;
                        pstage   = 3'(ev.planner_state - PL_STAGE1);
                        tgt      = state_t'(5'(ST_STAGE1) + {2'b00, pstage});
                    end
                    else if (ev.planner_state == PL_SETTLE)
                    begin
                        tgt = ST_SETTLE;
                    end
                    else if (ev.planner_state == PL_VALIDATE)
                    begin
                        tgt = ST_VALIDATE;
                    end
                    else
                    begin
                        tgt = ST_REPORT;
                    end

                    // Stages only move forward
                    if (tgt == ST_ZERO)
                    begin
                        allowed = 1'b0;
                    end
                    else if (is_stage)
                    begin
                        allowed = (cur_state_reg == ST_ZERO || cur_state_reg == ST_SETTLE) &&
                                  (stage_reg == STAGE_NONE || pstage > stage_reg);
                    end
                    else if (tgt == ST_SETTLE)
                    begin
                        allowed = cur_state_reg >= ST_STAGE1 && cur_state_reg <= ST_STAGE4;
                    end
                    else if (tgt == ST_VALIDATE)
                    begin
                        allowed = cur_state_reg == ST_SETTLE;
                    end
                    else
                    begin
                        allowed = cur_state_reg == ST_VALIDATE;
                    end

                    if (tgt == cur_state_reg)
                    begin
                        st = STAT_OK;
                    end
                    else if (allowed)
                    begin
                        if (is_stage)
                        begin
                            stage_next = pstage;
                        end
                        go = 1'b1; go_state = tgt; go_reason = RS_DISPENSE; st = STAT_OK;
                    end
                end
            end
            REQ_REPORT_DONE:
            begin
                if (cur_state_reg == ST_REPORT)
                begin
                    go = 1'b1; go_state = ST_CLEANUP; go_reason = RS_COMPLETE; st = STAT_OK;
                    session_next = 1'b0;
                    stage_next   = STAGE_NONE;
                end
            end
            REQ_CLEANUP_DONE:
            begin
                if (cur_state_reg == ST_CLEANUP)
                begin
                    go = 1'b1; go_state = ST_READY; go_reason = RS_COMPLETE; st = STAT_OK;
                end
            end
            REQ_AUTOCHK:
            begin
                if (cur_state_reg == ST_READY)
                begin
                    go = 1'b1; go_state = ST_AUTOCHK; go_reason = RS_OPERATOR; st = STAT_OK;
                end
            end
            REQ_AUTOCHK_DONE, REQ_CAL_DONE:
            begin
                if ((ev.req_type == REQ_AUTOCHK_DONE && cur_state_reg == ST_AUTOCHK) ||
                    (ev.req_type == REQ_CAL_DONE && cur_state_reg == ST_MANCAL))
                begin
                    go = 1'b1;
                    if (ev.pass_flag)
                    begin
                        go_state = ST_READY; go_reason = RS_COMPLETE; st = STAT_OK;
                    end
                    else
                    begin
                        go_state = ST_FAULT; go_reason = RS_FAILED; st = STAT_VERIFY;
                    end
                end
            end
            REQ_CAL:
            begin
                if (cur_state_reg == ST_READY)
                begin
                    go = 1'b1; go_state = ST_MANCAL; go_reason = RS_OPERATOR; st = STAT_OK;
                end
            end
            REQ_SERVICE:
            begin
                if (cur_state_reg == ST_READY)
                begin
                    go = 1'b1; go_state = ST_SERVICE; go_reason = RS_OPERATOR; st = STAT_OK;
                end
            end
            REQ_SERVICE_EXIT:
            begin
                if (cur_state_reg == ST_SERVICE)
                begin
                    go = 1'b1; go_state = ST_SELF_TEST; go_reason = RS_SUPRESET;
                    st = STAT_OK;
                end
            end
            REQ_FAULT:
            begin
                session_next = 1'b0;
                stage_next   = STAGE_NONE;
                st           = STAT_OK;
                if (cur_state_reg != ST_ESTOP && cur_state_reg != ST_FAULT)
                begin
                    go = 1'b1; go_state = ST_FAULT; go_reason = RS_FAULT;
                end
            end
            REQ_ESTOP:
            begin
                session_next = 1'b0;
                stage_next   = STAGE_NONE;
                st           = STAT_OK;
                if (cur_state_reg != ST_ESTOP)
                begin
                    go = 1'b1; go_state = ST_ESTOP; go_reason = RS_ESTOP;
                end
            end
            REQ_RESET:
            begin
                if (cur_state_reg != ST_FAULT && cur_state_reg != ST_ESTOP)
                begin
                    st = STAT_INVALID;
                end
                else if (!ev.pass_flag || !ev.faults_clear)
                begin
                    st = STAT_FAULT;
                end
                else
                begin
                    session_next = 1'b0;
                    stage_next   = STAGE_NONE;
                    go = 1'b1; go_state = ST_SELF_TEST; go_reason = RS_SUPRESET;
                    st = STAT_OK;
                end
            end
            default:
            begin
                st = STAT_INVALID;
            end
        endcase
    end

    // Apply the transition record and saturating count
    always_comb
    begin
        cur_state_next  = cur_state_reg;
        rec_prev_next   = rec_prev_reg;
        rec_reason_next = rec_reason_reg;
        count_next      = count_reg;
        if (go)
        begin
            cur_state_next  = go_state;
            rec_prev_next   = cur_state_reg;
            rec_reason_next = go_reason;
            if (count_reg != '1)
            begin
                count_next = count_reg + 64'd1;
            end
        end
    end

    // Result for this event
    assign res.status           = st;
    assign res.sys_state        = cur_state_next;
    assign res.prev_state       = rec_prev_next;
    assign res.last_reason      = rec_reason_next;
    assign res.transition_count = count_next;
    assign res.session_active   = session_next;
    assign res.did_transition   = go;

    // Advance state on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg  <= ST_BOOT;
            session_reg    <= 1'b0;
            stage_reg      <= STAGE_NONE;
            count_reg      <= 64'd0;
            rec_prev_reg   <= ST_BOOT;
            rec_reason_reg <= RS_NORMAL;
        end
        else if (step)
        begin
            cur_state_reg  <= cur_state_next;
            session_reg    <= session_next;
            stage_reg      <= stage_next;
            count_reg      <= count_next;
            rec_prev_reg   <= rec_prev_next;
            rec_reason_reg <= rec_reason_next;
        end
    end

endmodule

>>> rtl/dsf_out_reg.sv
// Output register stage: holds one result until the receiver takes it.
module dsf_out_reg
    import dsf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    output logic can_load,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    // Free when empty or when the held result transfers now
    assign can_load  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign res       = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

>>> rtl/dispenser_supervisory_fsm.sv
// Top level of the dispenser supervisory FSM.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event: req_type, pass_flag,
//   faults_clear, planner_state. Output channel (out_valid/out_ready) carries
//   one result per event: status, sys_state, prev_state, last_reason,
//   transition_count, session_active, did_transition.
//   An event is captured in the input register on transfer, evaluated against
//   the state registers once the output register has room, and its result is
//   registered in the output register, which raises out_valid. Throughput is
//   one event per cycle while out_ready stays high; the state update is a
//   single registered pass over the event decode and the 64-bit count adder.
//   At reset the machine is in BOOT, no session, no stage, count zero, and
//   both stages are empty. When the receiver stalls, the output register
//   holds its result, the input register holds one more event, and in_ready
//   drops once both are full; in_ready follows out_ready in the same cycle.
`include "dispenser_supervisory_fsm_assert.svh"
module dispenser_supervisory_fsm
    import dsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  req_type,
    input  logic        pass_flag,
    input  logic        faults_clear,
    input  logic [3:0]  planner_state,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  sys_state,
    output logic [4:0]  prev_state,
    output logic [2:0]  last_reason,
    output logic [63:0] transition_count,
    output logic        session_active,
    output logic        did_transition
);

    ev_t  ev_in;
    ev_t  ev;
    logic ev_vld;
    logic can_load;
    logic step;
    res_t res_core;
    res_t res;

    assign ev_in.req_type      = req_type;
    assign ev_in.pass_flag     = pass_flag;
    assign ev_in.faults_clear  = faults_clear;
    assign ev_in.planner_state = planner_state;

    // Evaluate the held event when the output register has room
    assign step = ev_vld && can_load;

    dsf_in_reg u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .ev_in    (ev_in),
        .take     (step),
        .ev_vld   (ev_vld),
        .ev       (ev)
    );

    dsf_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .ev    (ev),
        .res   (res_core)
    );

    dsf_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_in    (res_core),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign status           = res.status;
    assign sys_state        = res.sys_state;
    assign prev_state       = res.prev_state;
    assign last_reason      = res.last_reason;
    assign transition_count = res.transition_count;
    assign session_active   = res.session_active;
    assign did_transition   = res.did_transition;

    // A transition always leaves the state it came from
    `DSF_ASSERT_IMP(a_trans_moves, out_valid && did_transition, prev_state != sys_state)
    // A counted transition never leaves the count at zero
    `DSF_ASSERT_IMP(a_trans_counted, out_valid && did_transition, transition_count != 64'd0)
    // No session survives in FAULT or ESTOP
    `DSF_ASSERT_IMP(a_no_session_fault,
        out_valid && (sys_state == ST_FAULT || sys_state == ST_ESTOP), !session_active)
    // An evaluated event shows up at the output on the next cycle
    `DSF_ASSERT_NXT(a_step_lands, step, out_valid)

endmodule

>>> tb/sv/dsf_checker.sv
`timescale 1ns / 100ps
// Checker for the dispenser supervisory FSM: predicts each result and compares.
module dsf_checker
    import dsf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [4:0]  req_type,
    input  logic        pass_flag,
    input  logic        faults_clear,
    input  logic [3:0]  planner_state,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [4:0]  sys_state,
    input  logic [4:0]  prev_state,
    input  logic [2:0]  last_reason,
    input  logic [63:0] transition_count,
    input  logic        session_active,
    input  logic        did_transition,
    output int          fail_count,
    output int          pending_count
);

    // Shadow copy of the supervisory state
    state_t      fsm_state;
    logic        fsm_session;
    logic [2:0]  fsm_stage;
    logic [63:0] fsm_count;
    state_t      fsm_prev;
    reason_t     fsm_reason;
    logic        fsm_moved;

    // Outcomes of accepted events, oldest first
    res_t event_outcomes[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("%0t mismatch on %s: got %0h, predicted %0h",
                 $realtime, what, got, want);
    endtask

    // Take a transition and bump the saturating count
    function automatic void move_to(state_t next, reason_t why);
        fsm_prev = fsm_state;
        fsm_state = next;
        if (fsm_count != '1)
            fsm_count = fsm_count + 64'd1;
        fsm_reason = why;
        fsm_moved = 1'b1;
    endfunction

    function automatic status_t step_from(state_t need, state_t next, reason_t why);
        if (fsm_state != need)
            return STAT_INVALID;
        move_to(next, why);
        return STAT_OK;
    endfunction

    // Completion event with a pass/fail verdict
    function automatic status_t check_result(state_t need, logic ok, state_t good);
        reason_t why;
        if (fsm_state != need)
            return STAT_INVALID;
        if (ok)
        begin
            if (good == ST_READY && need != ST_ZERO && need != ST_SELF_TEST)
                why = RS_COMPLETE;
            else
                why = RS_NORMAL;
            move_to(good, why);
            return STAT_OK;
        end
        move_to(ST_FAULT, RS_FAILED);
        return STAT_VERIFY;
    endfunction

    function automatic void enter_estop();
        fsm_session = 1'b0;
        fsm_stage = STAGE_NONE;
        if (fsm_state != ST_ESTOP)
            move_to(ST_ESTOP, RS_ESTOP);
    endfunction

    // Planner report: stages only move forward, repeats are no-ops
    function automatic status_t planner_report(logic [3:0] plan);
        state_t     next;
        logic [2:0] stage;
        logic       allowed;
        stage = STAGE_NONE;
        next = fsm_state;
        allowed = 1'b0;
        if (plan == PL_ESTOP)
        begin
            enter_estop();
            return STAT_FAULT;
        end
        if (fsm_state == ST_ESTOP || fsm_state == ST_FAULT)
            return STAT_FAULT;
        if (!fsm_session || fsm_state < ST_ZERO || fsm_state == ST_READY
            || fsm_state > ST_REPORT)
            return STAT_INVALID;
        if (plan <= PL_VERIFY)
            next = ST_ZERO;
        else if (plan <= PL_STAGE4)
        begin
            stage = 3'(plan - PL_STAGE1);
            next = state_t'(ST_STAGE1 + stage);
        end
        else if (plan == PL_SETTLE)
            next = ST_SETTLE;
        else if (plan == PL_VALIDATE)
            next = ST_VALIDATE;
        else if (plan == PL_COMPLETE)
            next = ST_REPORT;
        else if (plan <= PL_FAULT)
        begin
            fsm_session = 1'b0;
            move_to(ST_FAULT, RS_FAILED);
            return STAT_FAULT;
        end
        else
            return STAT_INVALID;

        if (next == fsm_state)
            return STAT_OK;

        if (next == ST_ZERO)
            allowed = 1'b0;
        else if (stage != STAGE_NONE)
            allowed = (fsm_state == ST_ZERO || fsm_state == ST_SETTLE)
                      && (fsm_stage == STAGE_NONE || stage > fsm_stage);
        else if (next == ST_SETTLE)
            allowed = fsm_state >= ST_STAGE1 && fsm_state <= ST_STAGE4;
        else if (next == ST_VALIDATE)
            allowed = fsm_state == ST_SETTLE;
        else
            allowed = fsm_state == ST_VALIDATE;

        if (!allowed)
            return STAT_INVALID;
        if (stage != STAGE_NONE)
            fsm_stage = stage;
        move_to(next, RS_DISPENSE);
        return STAT_OK;
    endfunction

    // Apply one event to the shadow state and build its result
    function automatic res_t apply_event(logic [4:0] req, logic pf, logic fc,
                                         logic [3:0] plan);
        status_t st;
        res_t    r;
        fsm_moved = 1'b0;
        st = STAT_INVALID;
        case (req)
            REQ_BOOT_DONE:     st = step_from(ST_BOOT, ST_SELF_TEST, RS_NORMAL);
            REQ_SELFTEST_DONE: st = check_result(ST_SELF_TEST, pf, ST_WARMUP);
            REQ_WARMUP_DONE:   st = step_from(ST_WARMUP, ST_ZERO, RS_NORMAL);
            REQ_ZERO_DONE:
            begin
                if (fsm_session)
                    st = STAT_INVALID;
                else
                    st = check_result(ST_ZERO, pf, ST_READY);
            end
            REQ_DISPENSE:
            begin
                st = step_from(ST_READY, ST_ZERO, RS_OPERATOR);
                if (st == STAT_OK)
                begin
                    fsm_session = 1'b1;
                    fsm_stage = STAGE_NONE;
                end
            end
            REQ_PLANNER_SYNC:  st = planner_report(plan);
            REQ_REPORT_DONE:
            begin
                st = step_from(ST_REPORT, ST_CLEANUP, RS_COMPLETE);
                if (st == STAT_OK)
                begin
                    fsm_session = 1'b0;
                    fsm_stage = STAGE_NONE;
                end
            end
            REQ_CLEANUP_DONE:  st = step_from(ST_CLEANUP, ST_READY, RS_COMPLETE);
            REQ_AUTOCHK:       st = step_from(ST_READY, ST_AUTOCHK, RS_OPERATOR);
            REQ_AUTOCHK_DONE:  st = check_result(ST_AUTOCHK, pf, ST_READY);
            REQ_CAL:           st = step_from(ST_READY, ST_MANCAL, RS_OPERATOR);
            REQ_CAL_DONE:      st = check_result(ST_MANCAL, pf, ST_READY);
            REQ_SERVICE:       st = step_from(ST_READY, ST_SERVICE, RS_OPERATOR);
            REQ_SERVICE_EXIT:  st = step_from(ST_SERVICE, ST_SELF_TEST, RS_SUPRESET);
            REQ_FAULT:
            begin
                fsm_session = 1'b0;
                fsm_stage = STAGE_NONE;
                if (fsm_state != ST_ESTOP && fsm_state != ST_FAULT)
                    move_to(ST_FAULT, RS_FAULT);
                st = STAT_OK;
            end
            REQ_ESTOP:
            begin
                enter_estop();
                st = STAT_OK;
            end
            REQ_RESET:
            begin
                if (fsm_state != ST_FAULT && fsm_state != ST_ESTOP)
                    st = STAT_INVALID;
                else if (!pf || !fc)
                    st = STAT_FAULT;
                else
                begin
                    fsm_session = 1'b0;
                    fsm_stage = STAGE_NONE;
                    move_to(ST_SELF_TEST, RS_SUPRESET);
                    st = STAT_OK;
                end
            end
            default:           st = STAT_INVALID;
        endcase
        r.status = st;
        r.sys_state = fsm_state;
        r.prev_state = fsm_prev;
        r.last_reason = fsm_reason;
        r.transition_count = fsm_count;
        r.session_active = fsm_session;
        r.did_transition = fsm_moved;
        return r;
    endfunction

    // Check result transfers against the oldest outcome, then queue new events
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            fsm_state = ST_BOOT;
            fsm_session = 1'b0;
            fsm_stage = STAGE_NONE;
            fsm_count = '0;
            fsm_prev = ST_BOOT;
            fsm_reason = RS_NORMAL;
            fsm_moved = 1'b0;
            event_outcomes.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (event_outcomes.size() == 0)
                    report_mismatch("result with no event", 64'd0, 64'd0);
                else
                begin
                    want = event_outcomes.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (sys_state !== want.sys_state)
                        report_mismatch("sys_state", 64'(sys_state),
                                        64'(want.sys_state));
                    if (prev_state !== want.prev_state)
                        report_mismatch("prev_state", 64'(prev_state),
                                        64'(want.prev_state));
                    if (last_reason !== want.last_reason)
                        report_mismatch("last_reason", 64'(last_reason),
                                        64'(want.last_reason));
                    if (transition_count !== want.transition_count)
                        report_mismatch("transition_count", transition_count,
                                        want.transition_count);
                    if (session_active !== want.session_active)
                        report_mismatch("session_active", 64'(session_active),
                                        64'(want.session_active));
                    if (did_transition !== want.did_transition)
                        report_mismatch("did_transition", 64'(did_transition),
                                        64'(want.did_transition));
                end
            end
            if (in_valid && in_ready)
                event_outcomes.push_back(apply_event(req_type, pass_flag, faults_clear,
                                                     planner_state));
            pending_count = event_outcomes.size();
        end
    end

endmodule

>>> tb/sv/tb_dispenser_supervisory_fsm.sv
`timescale 1ns / 100ps
// Testbench top for the dispenser supervisory FSM: event stimulus, handshake timing and verdict.
module tb_dispenser_supervisory_fsm;
    import dsf_pkg::*;

    localparam logic [4:0] REQ_UNKNOWN_TOP = 5'd31;
    localparam logic [3:0] PL_INVALID_TOP  = 4'd15;
    localparam int         EVENT_TARGET    = 1750;
    localparam int         LONG_STALL      = 90;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [4:0]  req_type;
    logic        pass_flag;
    logic        faults_clear;
    logic [3:0]  planner_state;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [4:0]  sys_state;
    logic [4:0]  prev_state;
    logic [2:0]  last_reason;
    logic [63:0] transition_count;
    logic        session_active;
    logic        did_transition;
    int          fail_count;
    int          pending_count;

    int events_sent;
    bit sender_burst;
    bit receiver_burst;
    bit stall_request;

    dispenser_supervisory_fsm dut (.*);

    dsf_checker u_checker (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Drive one event and hold it until the transfer
    task automatic send_event(input logic [4:0] req, input bit pf, input bit fc,
                              input logic [3:0] plan);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        pass_flag <= pf;
        faults_clear <= fc;
        planner_state <= plan;
        do @(posedge clk); while (!in_ready);
        events_sent++;
        if ($urandom_range(0, 59) == 0)
            sender_burst = !sender_burst;
    endtask

    task automatic post(input req_t req, input bit pf);
        send_event(req, pf, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endtask

    task automatic plan_report(input logic [3:0] plan);
        send_event(REQ_PLANNER_SYNC, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), plan);
    endtask

    function automatic bit draw_pass();
        return $urandom_range(0, 6) != 0;
    endfunction

    // Drop valid and wait until every result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    // Force a latched fault, then a supervised reset and bring-up back to READY
    task automatic recover();
        if ($urandom_range(0, 1))
            post(REQ_FAULT, 1'($urandom_range(0, 1)));
        else
            post(REQ_ESTOP, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0)
            send_event(REQ_RESET, 1'($urandom_range(0, 1)), 1'b0, 4'($urandom_range(0, 15)));
        send_event(REQ_RESET, 1'b1, 1'b1, 4'($urandom_range(0, 15)));
        post(REQ_SELFTEST_DONE, 1'b1);
        post(REQ_WARMUP_DONE, 1'($urandom_range(0, 1)));
        post(REQ_ZERO_DONE, 1'b1);
    endtask

    // Occasionally throw an off-script event into a sequence
    task automatic maybe_upset(inout bit upset);
        if ($urandom_range(0, 39) == 0)
        begin
            upset = 1'b1;
            if ($urandom_range(0, 1))
                send_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            else
                plan_report(4'($urandom_range(0, 15)));
        end
    endtask

    // Full dispense session: forward stages with settles, validate, report, cleanup
    task automatic dispense_session();
        bit upset;
        bit any_stage;
        upset = 1'b0;
        any_stage = 1'b0;
        post(REQ_DISPENSE, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 2))
            plan_report($urandom_range(0, 1) ? PL_IDLE : PL_VERIFY);
        maybe_upset(upset);
        for (int s = 0; s < 4; s++)
        begin
            if ($urandom_range(0, 9) < 6 || (s == 3 && !any_stage))
            begin
                any_stage = 1'b1;
                repeat ($urandom_range(1, 2)) plan_report(4'(PL_STAGE1 + s));
                maybe_upset(upset);
                repeat ($urandom_range(1, 2)) plan_report(PL_SETTLE);
                maybe_upset(upset);
            end
        end
        plan_report(PL_VALIDATE);
        maybe_upset(upset);
        repeat ($urandom_range(1, 2)) plan_report(PL_COMPLETE);
        maybe_upset(upset);
        post(REQ_REPORT_DONE, 1'($urandom_range(0, 1)));
        post(REQ_CLEANUP_DONE, 1'($urandom_range(0, 1)));
        if (upset)
            recover();
    endtask

    task automatic check_or_calibrate();
        bit ok;
        ok = draw_pass();
        if ($urandom_range(0, 1))
        begin
            post(REQ_AUTOCHK, 1'($urandom_range(0, 1)));
            post(REQ_AUTOCHK_DONE, ok);
        end
        else
        begin
            post(REQ_CAL, 1'($urandom_range(0, 1)));
            post(REQ_CAL_DONE, ok);
        end
        if (!ok)
            recover();
    endtask

    task automatic service_visit();
        bit ok_self;
        bit ok_zero;
        ok_self = draw_pass();
        ok_zero = draw_pass();
        post(REQ_SERVICE, 1'($urandom_range(0, 1)));
        post(REQ_SERVICE_EXIT, 1'($urandom_range(0, 1)));
        post(REQ_SELFTEST_DONE, ok_self);
        post(REQ_WARMUP_DONE, 1'($urandom_range(0, 1)));
        post(REQ_ZERO_DONE, ok_zero);
        if (!(ok_self && ok_zero))
            recover();
    endtask

    // Mix of faults, estops, planner reports and resets with random clear flags, then a recovery
    task automatic fault_storm();
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 3))
                0: post(REQ_FAULT, 1'($urandom_range(0, 1)));
                1: post(REQ_ESTOP, 1'($urandom_range(0, 1)));
                2: plan_report($urandom_range(0, 1) ? PL_ESTOP : 4'($urandom_range(0, 15)));
                default: send_event(REQ_RESET, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            endcase
        end
        recover();
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
            send_event(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        recover();
    endtask

    // Receiver: random ready gaps, plus a long hold-off on request
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        receiver_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            else
            begin
                gap = receiver_burst ? 0 : $urandom_range(0, 9);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if ($urandom_range(0, 49) == 0)
                receiver_burst = !receiver_burst;
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        pass_flag = 1'b0;
        faults_clear = 1'b0;
        planner_state = '0;
        events_sent = 0;
        sender_burst = 1'b0;
        stall_request = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: wrong-state and unknown events, failed zeroing, latched fault,
        // stage ordering, repeated reports, estop priority
        post(REQ_ZERO_DONE, 1'b1);
        send_event(REQ_UNKNOWN_TOP, 1'b1, 1'b1, PL_INVALID_TOP);
        plan_report(PL_INVALID_TOP);
        post(REQ_BOOT_DONE, 1'b0);
        post(REQ_SELFTEST_DONE, 1'b1);
        post(REQ_WARMUP_DONE, 1'b0);
        post(REQ_ZERO_DONE, 1'b0);
        plan_report(PL_IDLE);
        send_event(REQ_RESET, 1'b1, 1'b0, PL_IDLE);
        send_event(REQ_RESET, 1'b1, 1'b1, PL_IDLE);
        post(REQ_SELFTEST_DONE, 1'b1);
        post(REQ_WARMUP_DONE, 1'b1);
        post(REQ_ZERO_DONE, 1'b1);
        post(REQ_DISPENSE, 1'b0);
        plan_report(PL_VERIFY);
        plan_report(PL_STAGE2);
        plan_report(PL_STAGE2);
        plan_report(PL_SETTLE);
        plan_report(PL_STAGE1);
        plan_report(PL_STAGE4);
        plan_report(PL_OVERFILL);
        post(REQ_FAULT, 1'b0);
        post(REQ_ESTOP, 1'b0);
        post(REQ_ESTOP, 1'b1);
        plan_report(PL_ESTOP);
        recover();

        // Pause until everything is back, then stall the receiver while events keep coming
        drain();
        stall_request = 1'b1;

        // Random: mostly well-formed sequences, some noise and broken ones
        while (events_sent < EVENT_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                dispense_session();
            else if (pick < 65)
                check_or_calibrate();
            else if (pick < 72)
                service_visit();
            else if (pick < 82)
                fault_storm();
            else if (pick < 92)
                noise_burst();
            else if (pick < 97)
            begin
                drain();
                sender_burst = !sender_burst;
            end
            else
                stall_request = 1'b1;
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> dispenser_supervisory_fsm.f
+incdir+rtl
rtl/dsf_pkg.sv
rtl/dsf_in_reg.sv
rtl/dsf_core.sv
rtl/dsf_out_reg.sv
rtl/dispenser_supervisory_fsm.sv
tb/sv/dsf_checker.sv
tb/sv/tb_dispenser_supervisory_fsm.sv
